@@ rtl/gne_pkg.sv @@
// Shared types, constants and helper functions of the grid neighbor expander.
package gne_pkg;

    localparam int MaxWidth  = 32;
    localparam int MaxHeight = 32;

    localparam int ModeW   = 2;
    localparam int XW      = 5;
    localparam int YW      = 5;
    localparam int CodeW   = 3;
    localparam int SizeW   = 6;
    localparam int CoordW  = 6;
    localparam int CfgIdxW = 2;
    localparam int MaskW   = 8;
    localparam int CountW  = 4;

    localparam logic [ModeW-1:0] ModeSet    = 2'd0;
    localparam logic [ModeW-1:0] ModeClear  = 2'd1;
    localparam logic [ModeW-1:0] ModeQuery4 = 2'd2;
    localparam logic [ModeW-1:0] ModeQuery8 = 2'd3;

    localparam logic [CfgIdxW-1:0] CfgGridWidth  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgGridHeight = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgWallCode   = 2'd2;

    localparam logic [SizeW-1:0] GridWidthRst  = 6'd32;
    localparam logic [SizeW-1:0] GridHeightRst = 6'd32;
    localparam logic [CodeW-1:0] WallCodeRst   = 3'd1;
    localparam logic [CodeW-1:0] CodeOpen      = 3'd0;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
        logic [CodeW-1:0] terrain_code;
    } t_in_word;

    typedef struct packed {
        logic [MaskW-1:0]  neighbor_mask;
        logic [CountW-1:0] neighbor_count;
        logic              center_walkable;
        logic [CodeW-1:0]  center_terrain;
    } t_out_word;

    typedef struct packed {
        logic [SizeW-1:0] grid_width;
        logic [SizeW-1:0] grid_height;
        logic [CodeW-1:0] wall_code;
    } t_cfg;

    // v / 3 by reciprocal multiply, exact for any 8-bit v
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [7:0] q;
        logic [7:0] r;
        q = div3(v);
        r = v - 8'({q, 1'b0} + 9'(q));
        return r[1:0];
    endfunction

endpackage

@@ rtl/gne_row_bank.sv @@
// One bank of terrain rows: bit-masked write port and registered read port.
module gne_row_bank #(
    parameter int ROW_W = 96,
    parameter int DEPTH = 11,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [ROW_W-1:0] i_wmask,
    input  logic [ROW_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int k = 0; k < ROW_W; k++) begin
                if (i_wmask[k]) begin
                    r_mem[i_waddr][k] <= i_wdata[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gne_row_store.sv @@
// Terrain store: rows interleaved over three banks, with a valid bit per row.
module gne_row_store #(
    parameter int MAX_WIDTH  = gne_pkg::MaxWidth,
    parameter int MAX_HEIGHT = gne_pkg::MaxHeight
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  gne_pkg::t_in_word                    i_word,
    input  gne_pkg::t_cfg                        i_cfg,
    output logic [MAX_WIDTH*gne_pkg::CodeW-1:0]  o_row_n,
    output logic [MAX_WIDTH*gne_pkg::CodeW-1:0]  o_row_c,
    output logic [MAX_WIDTH*gne_pkg::CodeW-1:0]  o_row_s
);
    import gne_pkg::*;

    localparam int RowW    = MAX_WIDTH * CodeW;
    localparam int BankN   = 3;
    localparam int Depth   = (MAX_HEIGHT + BankN - 1) / BankN;
    localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int RowIdxW = $clog2(MAX_HEIGHT);
    localparam int RowNW   = (RowIdxW > CoordW) ? RowIdxW : CoordW;
    localparam int ColIdxW = $clog2(MAX_WIDTH);
    localparam int ColNW   = (ColIdxW > CoordW) ? ColIdxW : CoordW;
    localparam logic [RowNW:0] RowLim = (RowNW + 1)'(MAX_HEIGHT);
    localparam logic [ColNW:0] ColLim = (ColNW + 1)'(MAX_WIDTH);

    logic [MAX_HEIGHT-1:0] r_row_valid;
    logic                  r_rd_ok [BankN];
    logic [1:0]            r_y_mod;

    logic [RowNW-1:0] y_row;
    logic [ColNW-1:0] x_col;
    logic [1:0]       y_mod;
    logic             query;
    logic             set_hit;
    logic             clear_hit;
    logic             set_full;
    logic [7:0]       wr_q;
    logic [AddrW-1:0] wr_addr;
    logic [RowW-1:0]  cell_mask;
    logic [RowW-1:0]  wr_mask;
    logic [RowW-1:0]  wr_data;

    logic [1:0]       rd_rel  [BankN];
    logic [RowNW-1:0] rd_row  [BankN];
    logic [7:0]       rd_q    [BankN];
    logic [AddrW-1:0] rd_addr [BankN];
    logic             rd_ok   [BankN];
    logic [RowW-1:0]  rd_data [BankN];

    assign y_row     = RowNW'(i_word.y);
    assign x_col     = ColNW'(i_word.x);
    assign y_mod     = mod3(8'(i_word.y));
    assign query     = (i_word.mode == ModeQuery4) || (i_word.mode == ModeQuery8);
    assign clear_hit = i_accept && (i_word.mode == ModeClear);
    assign set_hit   = i_accept && (i_word.mode == ModeSet)
                    && ({1'b0, i_word.x} < i_cfg.grid_width)
                    && ({1'b0, i_word.y} < i_cfg.grid_height)
                    && ({1'b0, x_col} < ColLim)
                    && ({1'b0, y_row} < RowLim);
    // a row unwritten since a clear is written whole: zeros but the set cell
    assign set_full  = !r_row_valid[y_row[RowIdxW-1:0]];
    assign wr_q      = div3(8'(i_word.y));
    assign wr_addr   = wr_q[AddrW-1:0];

    always_comb begin
        cell_mask = '0;
        wr_data   = '0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            if (ColNW'(c) == x_col) begin
                cell_mask[c*CodeW +: CodeW] = '1;
                wr_data[c*CodeW +: CodeW]   = i_word.terrain_code;
            end
        end
        wr_mask = set_full ? '1 : cell_mask;
    end

    // bank b holds the rows whose index mod 3 is b
    always_comb begin
        for (int b = 0; b < BankN; b++) begin
            rd_rel[b] = mod3(8'(b) + 8'd3 - 8'(y_mod));
            case (rd_rel[b])
                2'd0:    rd_row[b] = y_row;
                2'd1:    rd_row[b] = y_row + RowNW'(1);
                default: rd_row[b] = y_row - RowNW'(1);
            endcase
            rd_q[b]    = div3(8'(rd_row[b]));
            rd_addr[b] = rd_q[b][AddrW-1:0];
            rd_ok[b]   = ((rd_rel[b] != 2'd2) || (i_word.y != '0))
                      && ({1'b0, rd_row[b]} < RowLim)
                      && r_row_valid[rd_row[b][RowIdxW-1:0]];
        end
    end

    for (genvar b = 0; b < BankN; b++) begin : g_bank
        gne_row_bank #(
            .ROW_W (RowW),
            .DEPTH (Depth)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (set_hit && (y_mod == 2'(b))),
            .i_waddr (wr_addr),
            .i_wmask (wr_mask),
            .i_wdata (wr_data),
            .i_re    (i_accept && query),
            .i_raddr (rd_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (clear_hit) begin
            r_row_valid <= '0;
        end else if (set_hit) begin
            r_row_valid[y_row[RowIdxW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && query) begin
            r_y_mod <= y_mod;
            for (int b = 0; b < BankN; b++) begin
                r_rd_ok[b] <= rd_ok[b];
            end
        end
    end

    // route banks back to north, center and south rows; invalid rows read as open
    always_comb begin
        case (r_y_mod)
            2'd0: begin
                o_row_c = r_rd_ok[0] ? rd_data[0] : '0;
                o_row_s = r_rd_ok[1] ? rd_data[1] : '0;
                o_row_n = r_rd_ok[2] ? rd_data[2] : '0;
            end
            2'd1: begin
                o_row_c = r_rd_ok[1] ? rd_data[1] : '0;
                o_row_s = r_rd_ok[2] ? rd_data[2] : '0;
                o_row_n = r_rd_ok[0] ? rd_data[0] : '0;
            end
            default: begin
                o_row_c = r_rd_ok[2] ? rd_data[2] : '0;
                o_row_s = r_rd_ok[0] ? rd_data[0] : '0;
                o_row_n = r_rd_ok[1] ? rd_data[1] : '0;
            end
        endcase
    end

endmodule

@@ rtl/gne_neighbor_logic.sv @@
// Walkability of the 3x3 window around a cell and the neighbor mask it yields.
module gne_neighbor_logic #(
    parameter int MAX_WIDTH  = gne_pkg::MaxWidth,
    parameter int MAX_HEIGHT = gne_pkg::MaxHeight
) (
    input  logic [MAX_WIDTH*gne_pkg::CodeW-1:0] i_row_n,
    input  logic [MAX_WIDTH*gne_pkg::CodeW-1:0] i_row_c,
    input  logic [MAX_WIDTH*gne_pkg::CodeW-1:0] i_row_s,
    input  logic [gne_pkg::XW-1:0]              i_x,
    input  logic [gne_pkg::YW-1:0]              i_y,
    input  logic [gne_pkg::ModeW-1:0]           i_mode,
    input  gne_pkg::t_cfg                       i_cfg,
    output gne_pkg::t_out_word                  o_result
);
    import gne_pkg::*;

    localparam int RowW    = MAX_WIDTH * CodeW;
    localparam int RowIdxW = $clog2(MAX_HEIGHT);
    localparam int RowNW   = (RowIdxW > CoordW) ? RowIdxW : CoordW;
    localparam int ColIdxW = $clog2(MAX_WIDTH);
    localparam int ColNW   = (ColIdxW > CoordW) ? ColIdxW : CoordW;
    localparam logic [RowNW:0] RowLim = (RowNW + 1)'(MAX_HEIGHT);
    localparam logic [ColNW:0] ColLim = (ColNW + 1)'(MAX_WIDTH);

    logic [RowW-1:0]  rows   [3];
    logic [ColNW-1:0] cols   [3];
    logic [RowNW-1:0] rnums  [3];
    logic             col_in [3];
    logic             row_in [3];
    logic [CodeW-1:0] codes  [3][3];
    logic             walk   [3][3];
    logic             diag_on;
    logic [MaskW-1:0] mask;

    assign rows[0] = i_row_n;
    assign rows[1] = i_row_c;
    assign rows[2] = i_row_s;

    // index 0 is one step back (west or north), 1 the cell itself, 2 one step on
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cols[k]  = ColNW'(i_x) + ColNW'(k) - ColNW'(1);
            rnums[k] = RowNW'(i_y) + RowNW'(k) - RowNW'(1);
            col_in[k] = ((k != 0) || (i_x != '0))
                     && (cols[k] < ColNW'(i_cfg.grid_width))
                     && ({1'b0, cols[k]} < ColLim);
            row_in[k] = ((k != 0) || (i_y != '0))
                     && (rnums[k] < RowNW'(i_cfg.grid_height))
                     && ({1'b0, rnums[k]} < RowLim);
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                codes[r][k] = CodeOpen;
                for (int c = 0; c < MAX_WIDTH; c++) begin
                    if (ColNW'(c) == cols[k]) begin
                        codes[r][k] = rows[r][c*CodeW +: CodeW];
                    end
                end
                walk[r][k] = row_in[r] && col_in[k] && (codes[r][k] != i_cfg.wall_code);
            end
        end
    end

    // a diagonal, in query8 mode only, needs both cardinal cells beside it open
    assign diag_on = (i_mode == ModeQuery8);
    assign mask[0] = walk[0][1];
    assign mask[1] = walk[1][2];
    assign mask[2] = walk[2][1];
    assign mask[3] = walk[1][0];
    assign mask[4] = diag_on && walk[0][2] && walk[0][1] && walk[1][2];
    assign mask[5] = diag_on && walk[2][2] && walk[2][1] && walk[1][2];
    assign mask[6] = diag_on && walk[2][0] && walk[2][1] && walk[1][0];
    assign mask[7] = diag_on && walk[0][0] && walk[0][1] && walk[1][0];

    always_comb begin
        o_result.neighbor_mask   = mask;
        o_result.neighbor_count  = CountW'($countones(mask));
        o_result.center_walkable = walk[1][1];
        o_result.center_terrain  = (row_in[1] && col_in[1]) ? codes[1][1] : CodeOpen;
    end

endmodule

@@ rtl/grid_neighbor_expander.sv @@
// Top level of the grid neighbor expander: handshakes, configuration and result register.
//
// Input words carry a mode, a cell (x, y) and a terrain code. Set writes one cell
// when it lies inside the grid in use, clear opens every cell, and the two query
// modes return one output word: the N,E,S,W,NE,SE,SW,NW neighbor mask, its count,
// and the walkability and terrain of the cell itself. Set and clear return nothing.
// One word is taken every cycle while input ready is high. The accepting edge
// registers the three terrain rows around the cell out of the row banks; the result
// register then takes the query's result as soon as it can advance.
// When the receiver stalls, the result register holds its word and one more query
// waits in the row stage; input ready drops only when both are full.
// Reset opens every cell at once by clearing the per-row valid bits (no sweep),
// sets grid_width and grid_height to 32 and wall_code to 1, and empties the pipe.
// Configuration writes are always ready and take effect at once; write them while
// no query is in flight.
module grid_neighbor_expander #(
    parameter int MAX_WIDTH  = gne_pkg::MaxWidth,
    parameter int MAX_HEIGHT = gne_pkg::MaxHeight
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  gne_pkg::t_in_word            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output gne_pkg::t_out_word           o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gne_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [gne_pkg::SizeW-1:0]    i_cfg_data
);
    import gne_pkg::*;

    localparam int RowW = MAX_WIDTH * CodeW;

    t_cfg             r_cfg;
    logic             r_s1_valid;
    logic [XW-1:0]    r_s1_x;
    logic [YW-1:0]    r_s1_y;
    logic [ModeW-1:0] r_s1_mode;
    logic             r_out_valid;
    t_out_word        r_out_data;

    logic             in_accept;
    logic             in_query;
    logic             advance;
    logic [RowW-1:0]  row_n;
    logic [RowW-1:0]  row_c;
    logic [RowW-1:0]  row_s;
    t_out_word        result;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_query   = (i_in_data.mode == ModeQuery4) || (i_in_data.mode == ModeQuery8);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= GridWidthRst;
            r_cfg.grid_height <= GridHeightRst;
            r_cfg.wall_code   <= WallCodeRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgGridWidth:  r_cfg.grid_width  <= i_cfg_data;
                CfgGridHeight: r_cfg.grid_height <= i_cfg_data;
                CfgWallCode:   r_cfg.wall_code   <= i_cfg_data[CodeW-1:0];
                default: ;
            endcase
        end
    end

    gne_row_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .i_cfg    (r_cfg),
        .o_row_n  (row_n),
        .o_row_c  (row_c),
        .o_row_s  (row_s)
    );

    // row stage: only queries occupy it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_accept && in_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && in_query) begin
            r_s1_x    <= i_in_data.x;
            r_s1_y    <= i_in_data.y;
            r_s1_mode <= i_in_data.mode;
        end
    end

    gne_neighbor_logic #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_neighbor (
        .i_row_n  (row_n),
        .i_row_c  (row_c),
        .i_row_s  (row_s),
        .i_x      (r_s1_x),
        .i_y      (r_s1_y),
        .i_mode   (r_s1_mode),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // hold the word while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
